// ===== rtl/ptts_pkg.sv =====
// ----------------------------------------------------------------------------
// ptts_pkg: shared types and constants of the periodic task tick scheduler
// action and result codes, slot entry layout, controller/datapath bundles
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ptts_pkg;

  // input actions
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_ADD    = 2'd1;
  localparam logic [1:0] ACT_REMOVE = 2'd2;

  // result kinds
  localparam logic [2:0] KIND_FIRED    = 3'd0;
  localparam logic [2:0] KIND_ADDED    = 3'd1;
  localparam logic [2:0] KIND_REJECTED = 3'd2;
  localparam logic [2:0] KIND_REMOVED  = 3'd3;
  localparam logic [2:0] KIND_NONE     = 3'd4;

  // at most this many fire words per tick
  localparam int MAX_RESULTS = 16;
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  // restoring divider for the period
  localparam int DIV_STEPS = 16;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  // repeat limit meaning run forever
  localparam logic signed [16:0] REPEAT_FOREVER = -17'sd1;

  // one table slot
  typedef struct packed {
    logic [7:0]         task_id;
    logic [15:0]        period;
    logic [15:0]        tick_count;
    logic [15:0]        run_count;
    logic signed [16:0] repeat_limit;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic accept;      // input word taken
    logic idx_clr;
    logic idx_inc;
    logic rd_next;     // read slot idx+1 instead of idx
    logic tick_wr;     // write back updated slot during tick walk
    logic div_step;
    logic add_wr;      // store new slot at end of table
    logic rem_found;   // capture the slot being removed
    logic shift_wr;    // move slot idx down to idx-1
    logic rem_done;
    logic set_none;
    logic set_reject;
    logic flush;       // send pending word with last set
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic count_zero;
    logic full;
    logic idx_last;    // idx is the last occupied slot
    logic idx_end;     // idx has reached the slot count
    logic stall;       // tick fire cannot go out yet
    logic finished;    // slot under idx is finished
    logic div_last;
    logic flush_ok;    // pending word can move to the output register
    logic pend_empty;
  } sts_t;

endpackage

// ===== rtl/periodic_task_tick_scheduler_unit.sv =====
// ----------------------------------------------------------------------------
// periodic_task_tick_scheduler_unit: table of periodic task slots, top level
// tick: walks the occupied slots one slot per cycle through the table ram while
// no output stall holds it; on an empty table it returns straight to idle
// add: period set by the 16-step restoring divider; a full table rejects the add
// remove: an empty table answers none, else a search for a finished slot answers
// none when nothing is finished or removes it with compaction; output stalls hold
// the block; synchronous reset empties the table and sets the tick interval to 1
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module periodic_task_tick_scheduler_unit #(
  parameter int MAX_TASKS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [7:0]         in_task_id,
  input  logic [15:0]        in_interval,
  input  logic signed [16:0] in_repeat_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_kind,
  output logic [7:0]         out_task_id_res,
  output logic [3:0]         out_slot,
  output logic [4:0]         out_task_count,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  import ptts_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller
  ptts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  ptts_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_task_id      (in_task_id),
    .in_interval     (in_interval),
    .in_repeat_count (in_repeat_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_task_id_res (out_task_id_res),
    .out_slot        (out_slot),
    .out_task_count  (out_task_count),
    .out_last        (out_last)
  );

  // an add always keeps the block busy after it is accepted
  a_add_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == ACT_ADD) |=> !in_ready)
    else $error("add accepted but block idle next cycle");

  // a new result word only comes out of a busy block
  a_out_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result word produced while idle");

  // tick on an empty table completes at once
  a_empty_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_action == ACT_TICK && sts.count_zero) |=> in_ready)
    else $error("tick on empty table did not finish");

  // a full table never reports an empty one
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    sts.full |-> !sts.count_zero)
    else $error("table full and empty at once");

endmodule

// ===== rtl/ptts_ram.sv =====
// ----------------------------------------------------------------------------
// ptts_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/ptts_dp.sv =====
// ----------------------------------------------------------------------------
// ptts_dp: datapath of the periodic task tick scheduler
// slot table ram, period divider, pending and output word registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_dp #(
  parameter int MAX_TASKS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ptts_pkg::cmd_t      cmd,
  output ptts_pkg::sts_t      sts,
  input  logic [7:0]          in_task_id,
  input  logic [15:0]         in_interval,
  input  logic signed [16:0]  in_repeat_count,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_kind,
  output logic [7:0]          out_task_id_res,
  output logic [3:0]          out_slot,
  output logic [4:0]          out_task_count,
  output logic                out_last
);

  import ptts_pkg::*;

  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  logic [15:0]        tick_interval_r;
  logic [CW-1:0]      count_r;
  logic [CW-1:0]      idx_r;
  logic [7:0]         id_r;
  logic signed [16:0] limit_r;
  logic [15:0]        q_r;
  logic [15:0]        rem_r;
  logic [15:0]        div_d_r;
  logic [DIV_CW-1:0]  div_cnt_r;
  logic [RES_W-1:0]   n_r;
  logic               pend_valid_r;
  logic [2:0]         pend_kind_r;
  logic [7:0]         pend_id_r;
  logic [3:0]         pend_slot_r;
  logic [7:0]         gone_id_r;
  logic [3:0]         gone_slot_r;
  logic               out_valid_r;
  logic [2:0]         out_kind_r;
  logic [7:0]         out_id_r;
  logic [3:0]         out_slot_r;
  logic [4:0]         out_count_r;
  logic               out_last_r;

  logic [CW-1:0]      idx_p1;
  logic [CW-1:0]      idx_m1;
  logic [31:0]        idx_ext;
  logic [31:0]        count_ext;
  logic [3:0]         idx_slot;
  logic [3:0]         count_slot;
  logic [ENTRY_W-1:0] rd_data;
  logic [ENTRY_W-1:0] wr_data;
  logic [AW-1:0]      rd_addr;
  logic [AW-1:0]      wr_addr;
  logic               wr_en;
  entry_t             cur;
  entry_t             upd;
  entry_t             fresh;
  logic [16:0]        tick_p1;
  logic signed [16:0] run_s;
  logic               hit;
  logic               forever_run;
  logic               fire_ok;
  logic               report;
  logic               out_free;
  logic               push;
  logic [16:0]        div_sh;
  logic [17:0]        div_diff;
  logic               div_ge;
  logic [15:0]        period;

  // index arithmetic
  assign idx_p1     = idx_r + CW'(1);
  assign idx_m1     = idx_r - CW'(1);
  assign idx_ext    = 32'(idx_r);
  assign count_ext  = 32'(count_r);
  assign idx_slot   = idx_ext[3:0];
  assign count_slot = count_ext[3:0];

  // slot table
  ptts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_TASKS)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign rd_addr = cmd.rd_next ? idx_p1[AW-1:0] : idx_r[AW-1:0];
  assign cur     = entry_t'(rd_data);

  // tick evaluation of the slot under idx
  assign tick_p1     = {1'b0, cur.tick_count} + 17'd1;
  assign hit         = tick_p1 >= {1'b0, cur.period};
  assign run_s       = $signed({1'b0, cur.run_count});
  assign forever_run = cur.repeat_limit == REPEAT_FOREVER;
  assign fire_ok     = forever_run || (run_s < cur.repeat_limit);
  assign report      = hit && fire_ok && (n_r < RES_W'(MAX_RESULTS));
  assign out_free    = !out_valid_r || out_ready;

  always_comb begin
    upd            = cur;
    upd.tick_count = hit ? 16'd0 : tick_p1[15:0];
    if (hit && fire_ok && (cur.run_count != 16'hFFFF)) begin
      upd.run_count = cur.run_count + 16'd1;
    end
  end

  // serial restoring divider, ceiling taken from the remainder
  assign div_sh   = {rem_r, q_r[15]};
  assign div_diff = {1'b0, div_sh} - {2'b00, div_d_r};
  assign div_ge   = !div_diff[17];
  assign period   = q_r + {15'd0, (rem_r != 16'd0)};

  always_comb begin
    fresh              = '0;
    fresh.task_id      = id_r;
    fresh.period       = period;
    fresh.repeat_limit = limit_r;
  end

  // table write select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_r[AW-1:0];
    wr_data = upd;
    if (cmd.tick_wr) begin
      wr_en = 1'b1;
    end
    if (cmd.shift_wr) begin
      wr_en   = 1'b1;
      wr_addr = idx_m1[AW-1:0];
      wr_data = cur;
    end
    if (cmd.add_wr) begin
      wr_en   = 1'b1;
      wr_addr = count_r[AW-1:0];
      wr_data = fresh;
    end
  end

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_interval_r <= 16'd1;
    end else if (cfg_wr_en) begin
      tick_interval_r <= cfg_wr_data;
    end
  end

  // slot count and walk index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      n_r     <= '0;
    end else begin
      if (cmd.add_wr) begin
        count_r <= count_r + CW'(1);
      end else if (cmd.rem_done) begin
        count_r <= count_r - CW'(1);
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_p1;
      end
      if (cmd.accept) begin
        n_r <= '0;
      end else if (cmd.tick_wr && report) begin
        n_r <= n_r + RES_W'(1);
      end
    end
  end

  // input latch and divider
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      id_r      <= in_task_id;
      limit_r   <= in_repeat_count;
      q_r       <= in_interval;
      rem_r     <= 16'd0;
      div_d_r   <= (tick_interval_r == 16'd0) ? 16'd1 : tick_interval_r;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      q_r       <= {q_r[14:0], div_ge};
      rem_r     <= div_ge ? div_diff[15:0] : div_sh[15:0];
      div_cnt_r <= div_cnt_r + DIV_CW'(1);
    end
  end

  // slot being removed
  always_ff @(posedge clk) begin
    if (cmd.rem_found) begin
      gone_id_r   <= cur.task_id;
      gone_slot_r <= idx_slot;
    end
  end

  // pending word, held until the next one shows whether it is the last
  assign push = (cmd.tick_wr && report && pend_valid_r) || cmd.flush;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (cmd.set_reject || cmd.set_none || cmd.add_wr || cmd.rem_done ||
                 (cmd.tick_wr && report)) begin
      pend_valid_r <= 1'b1;
    end else if (cmd.flush) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_reject) begin
      pend_kind_r <= KIND_REJECTED;
      pend_id_r   <= in_task_id;
      pend_slot_r <= 4'd0;
    end else if (cmd.set_none) begin
      pend_kind_r <= KIND_NONE;
      pend_id_r   <= 8'd0;
      pend_slot_r <= 4'd0;
    end else if (cmd.add_wr) begin
      pend_kind_r <= KIND_ADDED;
      pend_id_r   <= id_r;
      pend_slot_r <= count_slot;
    end else if (cmd.rem_done) begin
      pend_kind_r <= KIND_REMOVED;
      pend_id_r   <= gone_id_r;
      pend_slot_r <= gone_slot_r;
    end else if (cmd.tick_wr && report) begin
      pend_kind_r <= KIND_FIRED;
      pend_id_r   <= cur.task_id;
      pend_slot_r <= idx_slot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_kind_r  <= pend_kind_r;
      out_id_r    <= pend_id_r;
      out_slot_r  <= pend_slot_r;
      out_count_r <= count_ext[4:0];
      out_last_r  <= cmd.flush;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_task_id_res = out_id_r;
  assign out_slot        = out_slot_r;
  assign out_task_count  = out_count_r;
  assign out_last        = out_last_r;

  // status to controller
  always_comb begin
    sts            = '0;
    sts.count_zero = count_r == '0;
    sts.full       = count_r >= CW'(MAX_TASKS);
    sts.idx_last   = idx_p1 == count_r;
    sts.idx_end    = idx_r == count_r;
    sts.stall      = report && pend_valid_r && !out_free;
    sts.finished   = !forever_run && (run_s >= cur.repeat_limit);
    sts.div_last   = div_cnt_r == DIV_CW'(DIV_STEPS - 1);
    sts.flush_ok   = pend_valid_r && out_free;
    sts.pend_empty = !pend_valid_r;
  end

endmodule

// ===== rtl/ptts_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptts_ctrl: controller of the periodic task tick scheduler
// sequences tick walks, period division, removal search and compaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ptts_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [1:0]     in_action,
  input  ptts_pkg::sts_t sts,
  output ptts_pkg::cmd_t cmd
);

  import ptts_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_TICK   = 7'b0000010,
    S_DIV    = 7'b0000100,
    S_ADD_WR = 7'b0001000,
    S_SEARCH = 7'b0010000,
    S_SHIFT  = 7'b0100000,
    S_FLUSH  = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          unique case (in_action)
            ACT_TICK: begin
              if (!sts.count_zero) begin
                state_nxt = S_TICK;
              end
            end
            ACT_ADD: begin
              if (sts.full) begin
                cmd.set_reject = 1'b1;
                state_nxt      = S_FLUSH;
              end else begin
                state_nxt = S_DIV;
              end
            end
            ACT_REMOVE: begin
              if (sts.count_zero) begin
                cmd.set_none = 1'b1;
                state_nxt    = S_FLUSH;
              end else begin
                state_nxt = S_SEARCH;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_TICK: begin
        if (!sts.stall) begin
          cmd.tick_wr = 1'b1;
          if (sts.idx_last) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_FLUSH;
          end else begin
            cmd.idx_inc = 1'b1;
            cmd.rd_next = 1'b1;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_FLUSH;
      end
      S_SEARCH: begin
        if (sts.finished) begin
          cmd.rem_found = 1'b1;
          cmd.idx_inc   = 1'b1;
          cmd.rd_next   = 1'b1;
          state_nxt     = S_SHIFT;
        end else if (sts.idx_last) begin
          cmd.set_none = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = S_FLUSH;
        end else begin
          cmd.idx_inc = 1'b1;
          cmd.rd_next = 1'b1;
        end
      end
      S_SHIFT: begin
        if (sts.idx_end) begin
          cmd.rem_done = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = S_FLUSH;
        end else begin
          cmd.shift_wr = 1'b1;
          cmd.idx_inc  = 1'b1;
          cmd.rd_next  = 1'b1;
        end
      end
      S_FLUSH: begin
        if (sts.pend_empty) begin
          state_nxt = S_IDLE;
        end else if (sts.flush_ok) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
